@@ rtl/p1305_pkg.sv @@
// Shared types, constants and limb helpers for the Poly1305 authenticator.
package p1305_pkg;

  localparam int LIMB_W = 26;
  localparam int NLIMB  = 5;
  localparam int H_W    = LIMB_W + 1;

  localparam logic [63:0] CLAMP_LO = 64'h0fff_fffc_0fff_ffff;
  localparam logic [63:0] CLAMP_HI = 64'h0fff_fffc_0fff_fffc;

  typedef logic [LIMB_W-1:0]  limb_t;
  typedef limb_t [NLIMB-1:0]  limbs_t;

  typedef enum logic [1:0] {
    REG_R_LOW  = 2'd0,
    REG_R_HIGH = 2'd1,
    REG_S_LOW  = 2'd2,
    REG_S_HIGH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    limbs_t m;
    logic   last;
  } blk_t;

  typedef struct packed {
    logic reserve;
    logic push;
  } oq_ctl_t;

  function automatic limbs_t split26(input logic [63:0] lo, input logic [63:0] hi);
    limbs_t o;
    o[0] = lo[25:0];
    o[1] = lo[51:26];
    o[2] = {hi[13:0], lo[63:52]};
    o[3] = hi[39:14];
    o[4] = {2'b00, hi[63:40]};
    return o;
  endfunction

endpackage

@@ rtl/p1305_front.sv @@
// Input side: accepts message blocks, splits them into padded limbs, queues them.
module p1305_front #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [63:0]       block_low,
  input  logic [63:0]       block_high,
  input  logic              last_block,
  output logic              q_vld,
  output p1305_pkg::blk_t   q_item,
  input  logic              q_pop
);
  import p1305_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  blk_t             mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wr_ok;
  blk_t             item;

  always_comb begin
    item      = '0;
    item.m    = split26(block_low, block_high);
    item.m[4] = item.m[4] | limb_t'(1 << 24);
    item.last = last_block;
  end

  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign wr_ok  = push && !full;
  assign q_vld  = (cnt_r != '0);
  assign q_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_ok) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_ok && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_ok && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

@@ rtl/p1305_core.sv @@
// Back end: multiply-reduce of the accumulator and tag finalization.
module p1305_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_vld,
  input  p1305_pkg::blk_t      q_item,
  output logic                 q_pop,
  input  p1305_pkg::limbs_t    r_limbs,
  input  logic [127:0]         s_pad,
  input  logic                 oq_room,
  output p1305_pkg::oq_ctl_t   oq_ctl,
  output logic [127:0]         tag
);
  import p1305_pkg::*;

  localparam int R5_W   = LIMB_W + 3;
  localparam int PROD_W = H_W + R5_W;
  localparam int D_W    = PROD_W + 3;
  localparam int E0_W   = D_W - LIMB_W + 3;
  localparam int G_W    = H_W + 1;

  logic [NLIMB-1:0][H_W-1:0]               acc_r, acc_nxt;
  logic [NLIMB-1:0][H_W-1:0]               h;
  logic [NLIMB-1:0][R5_W-1:0]              r5;
  logic [NLIMB-1:0][NLIMB-1:0][PROD_W-1:0] prod_r, prod_nxt;
  logic [NLIMB-1:0][D_W-1:0]               d_r, d_nxt;
  logic [E0_W-1:0]                         e0_r, e0_nxt;
  logic [NLIMB-2:0][LIMB_W-1:0]            eh_r, eh_nxt;
  logic [NLIMB-1:0][H_W-1:0]               f;
  logic [NLIMB-1:0][H_W-1:0]               th_r;
  logic [63:0]                             lo_r, lo_nxt, hi_r, hi_nxt;
  logic                                    v1_r, v2_r, v3_r, tv1_r, tv2_r;
  logic                                    last1_r, last2_r, last3_r;
  logic                                    issue;

  assign issue = q_vld && !v1_r && !v2_r && !v3_r && (!q_item.last || oq_room);
  assign q_pop = issue;
  assign oq_ctl.reserve = issue && q_item.last;
  assign oq_ctl.push    = tv2_r;
  assign tag = {hi_r, lo_r} + s_pad;

  // products of (acc + m) with r, high terms folded by 5
  always_comb begin
    for (int k = 0; k < NLIMB; k++) begin
      h[k]  = acc_r[k] + H_W'(q_item.m[k]);
      r5[k] = {3'b000, r_limbs[k]} + {1'b0, r_limbs[k], 2'b00};
    end
    for (int i = 0; i < NLIMB; i++) begin
      for (int j = 0; j < NLIMB; j++) begin
        if (i >= j) begin
          prod_nxt[i][j] = PROD_W'(h[j]) * PROD_W'(r_limbs[i - j]);
        end else begin
          prod_nxt[i][j] = PROD_W'(h[j]) * PROD_W'(r5[i - j + NLIMB]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NLIMB; i++) begin
      d_nxt[i] = '0;
      for (int j = 0; j < NLIMB; j++) begin
        d_nxt[i] = d_nxt[i] + D_W'(prod_r[i][j]);
      end
    end
  end

  // first carry pass
  always_comb begin
    logic [D_W-1:0] t;
    logic [D_W-1:0] cy;
    logic [LIMB_W-1:0] low0;
    cy   = '0;
    low0 = '0;
    for (int i = 0; i < NLIMB; i++) begin
      t  = d_r[i] + cy;
      cy = t >> LIMB_W;
      if (i == 0) begin
        low0 = t[LIMB_W-1:0];
      end else begin
        eh_nxt[i-1] = t[LIMB_W-1:0];
      end
    end
    e0_nxt = E0_W'(low0) + E0_W'(cy) + E0_W'({cy, 2'b00});
  end

  // second carry pass plus the final limb 0 carry
  always_comb begin
    logic [E0_W-1:0] t;
    logic [E0_W-1:0] cy;
    logic [E0_W-1:0] f0;
    logic [E0_W-1:0] f0c;
    cy   = e0_r >> LIMB_W;
    f[0] = '0;
    for (int i = 1; i < NLIMB; i++) begin
      t    = E0_W'(eh_r[i-1]) + cy;
      f[i] = H_W'(t[LIMB_W-1:0]);
      cy   = t >> LIMB_W;
    end
    f0   = E0_W'(e0_r[LIMB_W-1:0]) + cy + {cy[E0_W-3:0], 2'b00};
    f0c  = f0 >> LIMB_W;
    f[0] = H_W'(f0[LIMB_W-1:0]);
    f[1] = f[1] + H_W'(f0c);
    acc_nxt = last3_r ? '0 : f;
  end

  // full reduction and packing into 128 bits
  always_comb begin
    logic [G_W-1:0] t;
    logic [G_W-1:0] cy;
    logic [NLIMB-1:0][H_W-1:0] g;
    logic [NLIMB-1:0][H_W-1:0] hv;
    cy = G_W'(5);
    for (int i = 0; i < NLIMB; i++) begin
      t    = G_W'(th_r[i]) + cy;
      g[i] = H_W'(t[LIMB_W-1:0]);
      cy   = t >> LIMB_W;
    end
    hv     = (cy != '0) ? g : th_r;
    lo_nxt = 64'(hv[0]) | (64'(hv[1]) << 26) | (64'(hv[2]) << 52);
    hi_nxt = 64'(hv[2] >> 12) | (64'(hv[3]) << 14) | (64'(hv[4]) << 40);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      tv1_r <= 1'b0;
      tv2_r <= 1'b0;
    end else begin
      if (v3_r) begin
        acc_r <= acc_nxt;
      end
      v1_r  <= issue;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      tv1_r <= v3_r && last3_r;
      tv2_r <= tv1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r  <= prod_nxt;
      last1_r <= q_item.last;
    end
    if (v1_r) begin
      d_r     <= d_nxt;
      last2_r <= last1_r;
    end
    if (v2_r) begin
      e0_r    <= e0_nxt;
      eh_r    <= eh_nxt;
      last3_r <= last2_r;
    end
    if (v3_r && last3_r) begin
      th_r <= f;
    end
    if (tv1_r) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

endmodule

@@ rtl/p1305_outq.sv @@
// Tag queue with slot reservation so a tag in flight always has room.
module p1305_outq #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  p1305_pkg::oq_ctl_t  ctl,
  input  logic [127:0]        wdata,
  output logic                room,
  input  logic                pop,
  output logic                empty,
  output logic [127:0]        rdata
);
  import p1305_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [127:0]     mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic [CNT_W:0]   used;
  logic             rd_ok;

  assign used  = {1'b0, cnt_r} + {1'b0, pend_r};
  assign room  = (used < (CNT_W + 1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rd_ok = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    if (ctl.push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_ok) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (ctl.push && !rd_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!ctl.push && rd_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    if (ctl.reserve && !ctl.push) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!ctl.reserve && ctl.push) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      pend_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/poly1305_mac.sv @@
// Poly1305 MAC: the core takes 16-byte blocks one at a time and no new block until the
// previous one has gone through the accumulator feedback loop: parallel limb multiply,
// column sum, and two carry passes must finish before the next block can use the
// updated accumulator. Blocks queue in a small input FIFO and tags in a small
// output FIFO to absorb stalls on either side; a last block waits for tag queue room.
// Write key (r, s) via the cfg port only while idle; the block does not enforce it.
module poly1305_mac #(
  parameter int IN_DEPTH  = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  input  logic        in_last_block,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_tag_low,
  output logic [63:0] out_tag_high
);
  import p1305_pkg::*;

  logic [63:0]  r_low_r, r_high_r, s_low_r, s_high_r;
  limbs_t       r_limbs;
  logic         q_vld, q_pop, oq_room;
  blk_t         q_item;
  oq_ctl_t      oq_ctl;
  logic [127:0] tag, rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_low_r  <= '0;
      r_high_r <= '0;
      s_low_r  <= '0;
      s_high_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_idx))
        REG_R_LOW:  r_low_r  <= cfg_wdata;
        REG_R_HIGH: r_high_r <= cfg_wdata;
        REG_S_LOW:  s_low_r  <= cfg_wdata;
        REG_S_HIGH: s_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign r_limbs = split26(r_low_r & CLAMP_LO, r_high_r & CLAMP_HI);

  p1305_front #(
    .DEPTH(IN_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .full       (in_full),
    .block_low  (in_block_low),
    .block_high (in_block_high),
    .last_block (in_last_block),
    .q_vld      (q_vld),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  p1305_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_vld   (q_vld),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .r_limbs (r_limbs),
    .s_pad   ({s_high_r, s_low_r}),
    .oq_room (oq_room),
    .oq_ctl  (oq_ctl),
    .tag     (tag)
  );

  p1305_outq #(
    .DEPTH(OUT_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (oq_ctl),
    .wdata (tag),
    .room  (oq_room),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (rdata)
  );

  assign out_tag_low  = rdata[63:0];
  assign out_tag_high = rdata[127:64];

endmodule

@@ dv/poly1305_mac_checker.sv @@
`timescale 1ns / 100ps
// Poly1305 MAC checker: tracks key writes and accepted blocks, predicts tags, compares them.
module poly1305_mac_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_wdata,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  input  logic        in_last_block,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [63:0] out_tag_low,
  input  logic [63:0] out_tag_high,
  output int          mismatches,
  output int          tags_waiting,
  output int          tags_checked
);
  import p1305_pkg::*;

  localparam logic [63:0] R_MASK_LO = 64'h0fff_fffc_0fff_ffff;
  localparam logic [63:0] R_MASK_HI = 64'h0fff_fffc_0fff_fffc;
  localparam logic [63:0] LIMB_MASK = 64'h0000_0000_03ff_ffff;

  typedef logic [4:0][63:0] lanes_t;
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } tag_t;

  logic [63:0] key_r_lo, key_r_hi, key_s_lo, key_s_hi;
  lanes_t      acc;
  tag_t        expected_tags[$];

  function automatic lanes_t to_limbs(input logic [63:0] lo, input logic [63:0] hi);
    lanes_t o;
    o[0] = {38'd0, lo[25:0]};
    o[1] = {38'd0, lo[51:26]};
    o[2] = {38'd0, hi[13:0], lo[63:52]};
    o[3] = {38'd0, hi[39:14]};
    o[4] = {40'd0, hi[63:40]};
    return o;
  endfunction

  function automatic lanes_t carry_once(input lanes_t d);
    lanes_t      o;
    logic [63:0] c;
    o = d;
    for (int i = 0; i < 4; i++) begin
      c = o[i] >> 26;
      o[i] = o[i] & LIMB_MASK;
      o[i+1] = o[i+1] + c;
    end
    c = o[4] >> 26;
    o[4] = o[4] & LIMB_MASK;
    o[0] = o[0] + c * 64'd5;
    return o;
  endfunction

  // h = (h + m + 2^128) * r mod 2^130-5, kept in 26-bit limbs
  task automatic absorb_block(input logic [63:0] lo, input logic [63:0] hi);
    lanes_t      rl, hl, d;
    logic [63:0] c;
    rl = to_limbs(key_r_lo & R_MASK_LO, key_r_hi & R_MASK_HI);
    hl = to_limbs(lo, hi);
    hl[4] = hl[4] | (64'd1 << 24);
    for (int i = 0; i < 5; i++) hl[i] = acc[i] + hl[i];
    for (int i = 0; i < 5; i++) begin
      d[i] = '0;
      for (int j = 0; j < 5; j++) begin
        if (i - j >= 0) d[i] = d[i] + hl[j] * rl[i-j];
        else d[i] = d[i] + hl[j] * (rl[i-j+5] * 64'd5);
      end
    end
    d = carry_once(carry_once(d));
    c = d[0] >> 26;
    d[0] = d[0] & LIMB_MASK;
    d[1] = d[1] + c;
    acc = d;
  endtask

  function automatic tag_t final_tag();
    lanes_t      h, g;
    logic [63:0] c, lo, hi;
    tag_t        t;
    h = acc;
    c = 64'd5;
    for (int i = 0; i < 5; i++) begin
      g[i] = h[i] + c;
      c = g[i] >> 26;
      g[i] = g[i] & LIMB_MASK;
    end
    if (c != 0) h = g;
    lo = h[0] | (h[1] << 26) | (h[2] << 52);
    hi = (h[2] >> 12) | (h[3] << 14) | (h[4] << 40);
    t.lo = lo + key_s_lo;
    t.hi = hi + key_s_hi + {63'd0, t.lo < lo};
    return t;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s: expected %h got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    tag_t want;
    if (!rst_n) begin
      key_r_lo = '0;
      key_r_hi = '0;
      key_s_lo = '0;
      key_s_hi = '0;
      acc = '0;
      expected_tags.delete();
      mismatches = 0;
      tags_waiting = 0;
      tags_checked = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_idx))
          REG_R_LOW:  key_r_lo = cfg_wdata;
          REG_R_HIGH: key_r_hi = cfg_wdata;
          REG_S_LOW:  key_s_lo = cfg_wdata;
          REG_S_HIGH: key_s_hi = cfg_wdata;
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (expected_tags.size() == 0) begin
          report_mismatch("tag with no block pending, low word", '0, out_tag_low);
        end else begin
          want = expected_tags.pop_front();
          if (out_tag_low !== want.lo) report_mismatch("tag_low", want.lo, out_tag_low);
          if (out_tag_high !== want.hi) report_mismatch("tag_high", want.hi, out_tag_high);
          tags_checked++;
        end
      end
      if (in_push && !in_full) begin
        absorb_block(in_block_low, in_block_high);
        if (in_last_block) begin
          expected_tags.push_back(final_tag());
          acc = '0;
        end
      end
      tags_waiting = expected_tags.size();
    end
  end

endmodule

@@ dv/poly1305_mac_test.sv @@
`timescale 1ns / 100ps
// Poly1305 MAC testbench top: key loads, block and tag traffic with random gaps, verdict.
module poly1305_mac_test;
  import p1305_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_BLOCKS = 1400;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        cfg_wr_en     = 1'b0;
  logic [1:0]  cfg_idx       = '0;
  logic [63:0] cfg_wdata     = '0;
  logic        in_push       = 1'b0;
  logic [63:0] in_block_low  = '0;
  logic [63:0] in_block_high = '0;
  logic        in_last_block = 1'b0;
  logic        out_pop       = 1'b0;
  logic        in_full, out_empty;
  logic [63:0] out_tag_low, out_tag_high;

  int mismatches, tags_waiting, tags_checked;
  int blocks_sent = 0;
  int keys_loaded = 0;
  int idle_cycles = 0;
  bit steady      = 1'b0;  // no gaps on either side while set

  poly1305_mac u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_block_low  (in_block_low),
    .in_block_high (in_block_high),
    .in_last_block (in_last_block),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_tag_low   (out_tag_low),
    .out_tag_high  (out_tag_high)
  );

  poly1305_mac_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_block_low  (in_block_low),
    .in_block_high (in_block_high),
    .in_last_block (in_last_block),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_tag_low   (out_tag_low),
    .out_tag_high  (out_tag_high),
    .mismatches    (mismatches),
    .tags_waiting  (tags_waiting),
    .tags_checked  (tags_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_wr_en) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stalled for %0d cycles", idle_cycles);
      $display("poly1305_mac: mismatch");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi, input logic last);
    int gap;
    bit taken;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_block_low <= lo;
    in_block_high <= hi;
    in_last_block <= last;
    do begin
      @(negedge clk);
      taken = !in_full;
      @(posedge clk);
    end while (!taken);
    blocks_sent++;
  endtask

  // all tags back, then let blocks still inside the core finish
  task automatic settle();
    bit done;
    in_push <= 1'b0;
    do begin
      @(negedge clk);
      done = (tags_waiting == 0);
      @(posedge clk);
    end while (!done);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] rl, input logic [63:0] rh,
                          input logic [63:0] sl, input logic [63:0] sh);
    cfg_wr_en <= 1'b1;
    cfg_idx <= REG_R_LOW;
    cfg_wdata <= rl;
    @(posedge clk);
    cfg_idx <= REG_R_HIGH;
    cfg_wdata <= rh;
    @(posedge clk);
    cfg_idx <= REG_S_LOW;
    cfg_wdata <= sl;
    @(posedge clk);
    cfg_idx <= REG_S_HIGH;
    cfg_wdata <= sh;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    keys_loaded++;
  endtask

  task automatic load_random_key();
    case ($urandom_range(0, 7))
      0: load_key('1, '1, '1, '1);
      1: load_key('0, '0, rand_word(), rand_word());
      2: load_key(rand_word(), rand_word(), '0, '0);
      default: load_key({$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom});
    endcase
  endtask

  initial begin : tag_drain
    int gap;
    bit taken;
    forever begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do begin
        @(negedge clk);
        taken = !out_empty;
        @(posedge clk);
      end while (!taken);
    end
  end

  initial begin : stimulus
    int rand_sent;
    int phase_len;
    int phase_sent;
    int msg_len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero key after reset: every tag is zero
    send_block('1, '1, 1'b1);
    send_block('0, '0, 1'b1);
    settle();

    // all-ones key: clamp and pad carry-out
    load_key('1, '1, '1, '1);
    send_block('1, '1, 1'b0);
    send_block('1, '1, 1'b0);
    send_block('1, '1, 1'b1);
    send_block('0, '0, 1'b1);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);
    settle();

    // standard test key
    load_key(64'h336d_5557_78be_d685, 64'ha806_d542_fe52_447f,
             64'hfdb2_0dfb_8a80_0301, 64'h1bf5_4941_aff6_bf4a);
    send_block(64'h6172_676f_7470_7972, 64'h6f46_2063_6968_7061, 1'b0);
    send_block(64'h6573_6552_206d_7572, 64'h6f72_4720_6863_7261, 1'b1);
    send_block('1, '0, 1'b1);

    // key swapped in the middle of a message
    send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    settle();
    load_key({$urandom, $urandom}, {$urandom, $urandom}, '1, '1);
    send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
    settle();

    // zero r with a pad: tag equals the pad
    load_key('0, '0, {$urandom, $urandom}, {$urandom, $urandom});
    send_block('1, '1, 1'b0);
    send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
    settle();

    rand_sent = 0;
    while (rand_sent < RANDOM_BLOCKS) begin
      load_random_key();
      steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 200);
      if (phase_len > RANDOM_BLOCKS - rand_sent) phase_len = RANDOM_BLOCKS - rand_sent;
      phase_sent = 0;
      while (phase_sent < phase_len) begin
        msg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int b = 0; b < msg_len; b++) begin
          send_block(rand_word(), rand_word(), b == msg_len - 1);
          phase_sent++;
          if (b < msg_len - 1 && $urandom_range(0, 39) == 0) begin
            settle();
            load_random_key();
          end
        end
      end
      rand_sent += phase_sent;
      settle();
    end
    steady = 1'b0;
    settle();

    $display("covered %0d blocks under %0d key settings, %0d tags compared",
             blocks_sent, keys_loaded, tags_checked);
    if (mismatches == 0 && tags_waiting == 0) begin
      $display("poly1305_mac: match");
    end else begin
      $display("%0d mismatches, %0d tags never seen", mismatches, tags_waiting);
      $display("poly1305_mac: mismatch");
    end
    $finish;
  end

endmodule
